// File: hdl/ufs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_pkg: shared definitions for the union-find block
// Element-count default and the control state encoding.
// ----------------------------------------------------------------------------
package ufs_pkg;

  localparam int UFS_NODES_DEF = 1024;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_WALK   = 7'b0000100,
    ST_COMP   = 7'b0001000,
    ST_SZB    = 7'b0010000,
    ST_LINK   = 7'b0100000,
    ST_RESULT = 7'b1000000
  } ufs_state_t;

endpackage

// File: hdl/ufs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ufs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/union_find_by_size.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_by_size: disjoint-set union by size with path compression
// Joins the sets holding node_a and node_b and reports whether a merge
// happened. Parent links and set sizes live in two RAMs with registered reads.
// ----------------------------------------------------------------------------
// After reset the block sweeps both memories back to singleton sets, one
// entry per cycle, and stalls its input until the sweep is done. Each find
// reads its start element in the parent memory, walks the links to the
// root and then repoints each node on the walked path during path
// compression. When the roots differ, the block reads the second size and
// then writes the link and the summed size. Last, the result register is
// loaded; that step waits while an earlier result is still stalled. An
// item with an index at or above NODES goes straight from its transfer to
// the result state, and one whose elements are already joined skips the
// size work. The parent memory's single read port sets the pace: every
// walk step waits for its read.
module union_find_by_size
  import ufs_pkg::*;
#(
  parameter int NODES = UFS_NODES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [9:0] in_node_a,
  input  logic [9:0] in_node_b,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_merged
);

  localparam int IDX_W = $clog2(NODES);
  localparam int SZ_W  = $clog2(NODES + 1);

  ufs_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [IDX_W-1:0] root_r, root_nxt;
  logic [IDX_W-1:0] root_a_r, root_a_nxt;
  logic [IDX_W-1:0] node_b_r, node_b_nxt;
  logic             phase_b_r, phase_b_nxt;
  logic [SZ_W-1:0]  sa_r, sa_nxt;
  logic             res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_merged_r, out_merged_nxt;

  logic             par_we;
  logic [IDX_W-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
  logic             sz_we;
  logic [IDX_W-1:0] sz_waddr, sz_raddr;
  logic [SZ_W-1:0]  sz_wdata, sz_rdata;

  logic             in_xfer;
  logic             in_range;
  logic             find_done;
  logic [IDX_W-1:0] fnd_root;

  ufs_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_parent (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  ufs_ram #(.WIDTH(SZ_W), .DEPTH(NODES)) u_size (
    .clk   (clk),
    .we    (sz_we),
    .waddr (sz_waddr),
    .wdata (sz_wdata),
    .raddr (sz_raddr),
    .rdata (sz_rdata)
  );

  assign in_stall   = (state_r != ST_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign in_range   = (32'(in_node_a) < NODES) && (32'(in_node_b) < NODES);
  assign out_valid  = out_valid_r;
  assign out_merged = out_merged_r;

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cur_nxt        = cur_r;
    start_nxt      = start_r;
    root_nxt       = root_r;
    root_a_nxt     = root_a_r;
    node_b_nxt     = node_b_r;
    phase_b_nxt    = phase_b_r;
    sa_nxt         = sa_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_merged_nxt = out_merged_r;
    par_we         = 1'b0;
    par_waddr      = cur_r;
    par_wdata      = root_r;
    par_raddr      = cur_r;
    sz_we          = 1'b0;
    sz_waddr       = root_a_r;
    sz_wdata       = sa_r + sz_rdata;
    sz_raddr       = root_a_r;
    find_done      = 1'b0;
    fnd_root       = root_r;

    case (state_r)
      ST_CLEAR: begin
        par_we    = 1'b1;
        par_waddr = clr_cnt_r;
        par_wdata = clr_cnt_r;
        sz_we     = 1'b1;
        sz_waddr  = clr_cnt_r;
        sz_wdata  = SZ_W'(1);
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == IDX_W'(NODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        par_raddr = IDX_W'(in_node_a);
        if (in_xfer) begin
          if (in_range) begin
            cur_nxt     = IDX_W'(in_node_a);
            start_nxt   = IDX_W'(in_node_a);
            node_b_nxt  = IDX_W'(in_node_b);
            phase_b_nxt = 1'b0;
            state_nxt   = ST_WALK;
          end else begin
            res_nxt   = 1'b0;
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_WALK: begin
        if (par_rdata == cur_r) begin
          if (cur_r == start_r) begin
            find_done = 1'b1;
            fnd_root  = cur_r;
          end else begin
            // root found; rewalk from the start and repoint each node
            root_nxt  = cur_r;
            cur_nxt   = start_r;
            par_raddr = start_r;
            state_nxt = ST_COMP;
          end
        end else begin
          cur_nxt   = par_rdata;
          par_raddr = par_rdata;
        end
      end
      ST_COMP: begin
        par_we    = 1'b1;
        par_waddr = cur_r;
        par_wdata = root_r;
        if (par_rdata == root_r) begin
          find_done = 1'b1;
          fnd_root  = root_r;
        end else begin
          cur_nxt   = par_rdata;
          par_raddr = par_rdata;
        end
      end
      ST_SZB: begin
        sa_nxt    = sz_rdata;
        sz_raddr  = root_r;
        state_nxt = ST_LINK;
      end
      ST_LINK: begin
        par_we = 1'b1;
        sz_we  = 1'b1;
        if (sa_r < sz_rdata) begin
          par_waddr = root_a_r;
          par_wdata = root_r;
          sz_waddr  = root_r;
        end else begin
          par_waddr = root_r;
          par_wdata = root_a_r;
          sz_waddr  = root_a_r;
        end
        res_nxt   = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_merged_nxt = res_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // hand over from the first find to the second, then to the size lookup or, if both roots match, to the result
    if (find_done) begin
      if (!phase_b_r) begin
        root_a_nxt  = fnd_root;
        phase_b_nxt = 1'b1;
        cur_nxt     = node_b_r;
        start_nxt   = node_b_r;
        par_raddr   = node_b_r;
        state_nxt   = ST_WALK;
      end else if (fnd_root == root_a_r) begin
        res_nxt   = 1'b0;
        state_nxt = ST_RESULT;
      end else begin
        root_nxt  = fnd_root;
        sz_raddr  = root_a_r;
        state_nxt = ST_SZB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      phase_b_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      phase_b_r   <= phase_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    start_r      <= start_nxt;
    root_r       <= root_nxt;
    root_a_r     <= root_a_nxt;
    node_b_r     <= node_b_nxt;
    sa_r         <= sa_nxt;
    res_r        <= res_nxt;
    out_merged_r <= out_merged_nxt;
  end

`ifndef ASSERT_OFF
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result presented during memory clear");

  a_link_distinct_roots: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LINK) |-> (root_a_r != root_r))
    else $error("linking a root to itself");

  a_comp_skips_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP) |-> (cur_r != root_r))
    else $error("path compression rewrote the root");

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LINK) |->
      ((SZ_W + 1)'(sa_r) + (SZ_W + 1)'(sz_rdata) <= (SZ_W + 1)'(NODES)))
    else $error("merged set size exceeds element count");
`endif

endmodule

// File: dv/union_find_by_size_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_by_size_checker: scoreboard for the union-find block
// Watches both channels. Every input transfer is applied to a private
// disjoint-set store (union by size, path compression) to get the expected
// merged flag. Every output transfer is compared with the oldest expected flag.
// ----------------------------------------------------------------------------
module union_find_by_size_checker
  import ufs_pkg::*;
#(
  parameter int NODES = UFS_NODES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [9:0] in_node_a,
  input  logic [9:0] in_node_b,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_merged,
  output int         mismatch_count,
  output int         pending_count
);

  logic [9:0]  parent_q [NODES];
  logic [10:0] size_q   [NODES];
  logic        merged_expected_q [$];

  // Walk to the root, then repoint the walked path straight at it.
  function automatic logic [9:0] find_root(input logic [9:0] start);
    logic [9:0] root;
    logic [9:0] cur;
    logic [9:0] nxt;
    int         guard;
    root  = start;
    guard = 0;
    while (parent_q[root] != root && guard < NODES) begin
      root = parent_q[root];
      guard++;
    end
    cur   = start;
    guard = 0;
    while (cur != root && guard < NODES) begin
      nxt           = parent_q[cur];
      parent_q[cur] = root;
      cur           = nxt;
      guard++;
    end
    return root;
  endfunction

  function automatic logic join_sets(input logic [9:0] a, input logic [9:0] b);
    logic [9:0] root_a;
    logic [9:0] root_b;
    if (int'(a) >= NODES || int'(b) >= NODES) return 1'b0;
    root_a = find_root(a);
    root_b = find_root(b);
    if (root_a == root_b) return 1'b0;
    // Ties hang the second root under the first.
    if (size_q[root_a] < size_q[root_b]) begin
      parent_q[root_a] = root_b;
      size_q[root_b]   = size_q[root_b] + size_q[root_a];
    end else begin
      parent_q[root_b] = root_a;
      size_q[root_a]   = size_q[root_a] + size_q[root_b];
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    logic expected;
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) begin
        parent_q[i] = i[9:0];
        size_q[i]   = 11'd1;
      end
      merged_expected_q.delete();
      mismatch_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected = join_sets(in_node_a, in_node_b);
        merged_expected_q.insert(merged_expected_q.size(), expected);
      end
      if (out_valid && !out_stall) begin
        if (merged_expected_q.size() == 0) begin
          $error("out transfer with no expected result: merged=%0b", out_merged);
          mismatch_count <= mismatch_count + 1;
        end else begin
          expected = merged_expected_q.pop_front();
          if (out_merged !== expected) begin
            $error("merged mismatch: expected %0b, actual %0b", expected, out_merged);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
    pending_count <= merged_expected_q.size();
  end

endmodule

// File: dv/tb_union_find_by_size.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_union_find_by_size: testbench top for the union-find block
// Drives join requests (a directed set, then clustered and uniform random
// pairs) under three idle/stall mixes and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_union_find_by_size;

  localparam int RANDOM_PER_PHASE = 300;
  localparam int WINDOW           = 32;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [9:0] in_node_a  = '0;
  logic [9:0] in_node_b  = '0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic       out_merged;

  int mismatch_count;
  int pending_count;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  union_find_by_size dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_node_a  (in_node_a),
    .in_node_b  (in_node_b),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_merged (out_merged)
  );

  union_find_by_size_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_node_a      (in_node_a),
    .in_node_b      (in_node_b),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_merged     (out_merged),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("union_find_by_size verification failed");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= (rx_idle_pct > 0) && ($urandom_range(99) < rx_idle_pct);
  end

  // Hold the pair until the transfer; idle cycles go before it.
  task automatic send_pair(input logic [9:0] a, input logic [9:0] b);
    @(negedge clk);
    while ((tx_idle_pct > 0) && ($urandom_range(99) < tx_idle_pct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_node_a <= a;
    in_node_b <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic run_random(input int count);
    logic [9:0] base;
    logic [9:0] a;
    logic [9:0] b;
    int         pick;
    base = '0;
    for (int i = 0; i < count; i++) begin
      // Move the cluster window now and then so sets grow and then join up.
      if (i % 40 == 0) base = 10'($urandom_range(1023 - WINDOW + 1));
      pick = $urandom_range(99);
      if (pick < 55) begin
        a = base + 10'($urandom_range(WINDOW - 1));
        b = base + 10'($urandom_range(WINDOW - 1));
      end else if (pick < 60) begin
        a = 10'($urandom_range(1023));
        b = a;
      end else if (pick < 65) begin
        a = ($urandom_range(1)) ? 10'd1023 : 10'd0;
        b = 10'($urandom_range(1023));
      end else begin
        a = 10'($urandom_range(1023));
        b = 10'($urandom_range(1023));
      end
      send_pair(a, b);
    end
  endtask

  initial begin
    tx_idle_pct = 24;
    rx_idle_pct = 49;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // same element, ties, smaller under larger, same set, compression
    send_pair(10'd0,    10'd0);
    send_pair(10'd0,    10'd1);
    send_pair(10'd1,    10'd0);
    send_pair(10'd1023, 10'd1022);
    send_pair(10'd1022, 10'd0);
    send_pair(10'd2,    10'd1);
    send_pair(10'd3,    10'd4);
    send_pair(10'd5,    10'd6);
    send_pair(10'd3,    10'd5);
    send_pair(10'd4,    10'd6);
    send_pair(10'd6,    10'd1);
    send_pair(10'd1,    10'd6);
    send_pair(10'd682,  10'd341);
    send_pair(10'd512,  10'd511);
    send_pair(10'd341,  10'd512);
    send_pair(10'd1023, 10'd1023);
    send_pair(10'd0,    10'd1023);
    send_pair(10'd511,  10'd2);
    run_random(RANDOM_PER_PHASE);

    tx_idle_pct = 49;
    rx_idle_pct = 24;
    run_random(RANDOM_PER_PHASE);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(RANDOM_PER_PHASE);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_count == 0);
    repeat (64) @(posedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("union_find_by_size verification clean");
    end else begin
      $display("union_find_by_size verification failed");
    end
    $finish;
  end

endmodule
